FILE: rtl/lpwm_pkg.sv
// Shared types, constants and helpers for the PWM LED channel store.
// No dependencies; every other file imports this package.
`default_nettype none

package lpwm_pkg;

  localparam int CHANNELS_PER_DRIVER = 24;
  localparam int LEVEL_BITS          = 12;
  localparam int DEF_MAX_DRIVERS     = 4;

  localparam int FUNC_W     = 3;
  localparam int INDEX_W    = 7;
  localparam int VALUE_W    = 16;
  localparam int DRV_W      = 3;
  localparam int BIT_W      = 4;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX        = '1;
  localparam logic [LEVEL_BITS-1:0] GLOBAL_LEVEL_RST = LEVEL_MAX;
  localparam logic [DRV_W-1:0]      NUM_DRIVERS_RST  = DRV_W'(1);
  localparam logic [VALUE_W-1:0]    STATE_USE_GLOBAL = VALUE_W'(1);

  localparam logic [BIT_W-1:0] BIT_TOP     = BIT_W'(LEVEL_BITS - 1);
  localparam logic [BIT_W-1:0] LATCH_PHASE = BIT_W'(LEVEL_BITS);

  localparam logic [FUNC_W-1:0] FN_SET_PWM   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SET_STATE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SET_LED   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd3;
  localparam logic [FUNC_W-1:0] FN_WRITE     = 3'd4;
  localparam logic [FUNC_W-1:0] FN_TICK      = 3'd5;

  localparam logic [CFG_ADDR_W-1:0] CFG_NUM_DRIVERS  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_GLOBAL_LEVEL = 1'd1;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value_a;
    logic [VALUE_W-1:0] value_b;
    logic [VALUE_W-1:0] value_c;
  } item_t;

  typedef struct packed {
    logic serial_data;
    logic bit_strobe;
    logic latch_pulse;
    logic busy_res;
  } res_t;

  typedef struct packed {
    logic active;
    logic serial_data;
    logic bit_strobe;
    logic latch_pulse;
  } shift_stat_t;

  function automatic logic [LEVEL_BITS-1:0] clamp_level(input logic [VALUE_W-1:0] v);
    return (|v[VALUE_W-1:LEVEL_BITS]) ? LEVEL_MAX : v[LEVEL_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lpwm_store.sv
// Channel level memory: one write port, one registered read port.
// Depends on lpwm_pkg.
`default_nettype none

module lpwm_store #(
  parameter int DEPTH  = lpwm_pkg::DEF_MAX_DRIVERS * lpwm_pkg::CHANNELS_PER_DRIVER,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [ADDR_W-1:0]               waddr,
  input  logic [lpwm_pkg::LEVEL_BITS-1:0] wdata,
  input  logic [ADDR_W-1:0]               raddr,
  output logic [lpwm_pkg::LEVEL_BITS-1:0] rdata
);
  import lpwm_pkg::*;

  logic [LEVEL_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/lpwm_shift.sv
// Serial shift-out: level shift register, bit and channel counters, latch phase.
// Depends on lpwm_pkg; fed by lpwm_store through its registered read port.
`default_nettype none

module lpwm_shift #(
  parameter int ADDR_W = 7
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            launch,
  input  logic [ADDR_W-1:0]               top_chan,
  input  logic                            load,
  input  logic                            tick,
  input  logic [lpwm_pkg::LEVEL_BITS-1:0] rdata,
  output logic [ADDR_W-1:0]               raddr,
  output lpwm_pkg::shift_stat_t           stat
);
  import lpwm_pkg::*;

  logic                  active;
  logic                  pre;
  logic [ADDR_W-1:0]     chan;
  logic [BIT_W-1:0]      bitn;
  logic [LEVEL_BITS-1:0] shreg;
  logic                  latch_ph;
  logic                  shift_en;

  assign latch_ph = (bitn == LATCH_PHASE);
  assign shift_en = tick && active && !latch_ph;

  assign stat.active      = active;
  assign stat.serial_data = active && !latch_ph && shreg[LEVEL_BITS-1];
  assign stat.bit_strobe  = active && !latch_ph;
  assign stat.latch_pulse = active && latch_ph;

  // prefetch the next lower channel while the current one shifts
  assign raddr = pre ? chan : ((chan == '0) ? '0 : chan - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      pre    <= 1'b0;
      chan   <= '0;
      bitn   <= '0;
    end else if (launch) begin
      active <= 1'b1;
      pre    <= 1'b1;
      chan   <= top_chan;
      bitn   <= BIT_TOP;
    end else if (load) begin
      pre <= 1'b0;
    end else if (tick && active) begin
      if (latch_ph) begin
        active <= 1'b0;
        bitn   <= '0;
        chan   <= '0;
      end else if (bitn == '0) begin
        if (chan == '0) begin
          bitn <= LATCH_PHASE;
        end else begin
          chan <= chan - 1'b1;
          bitn <= BIT_TOP;
        end
      end else begin
        bitn <= bitn - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shreg <= rdata;
    end else if (shift_en) begin
      shreg <= (bitn == '0) ? rdata : {shreg[LEVEL_BITS-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/led_pwm_channel_store_shift_out.sv
// Top level: command decode, store sequencer (clearing pass, LED writes, load), result word.
// Depends on lpwm_pkg, lpwm_store and lpwm_shift.
//
// A word is taken at a clock edge with start high and busy low; its result word appears on
// res, marked by done, in the next cycle and for that cycle only, and is not held. set_pwm,
// set_state, tick and ignored words leave busy low, so ticks can follow back to back and shift
// one bit each. set_led holds busy in S_LED while it writes its three channels, one store
// write per channel; write holds it through S_LOAD0 and S_LOAD1 (store read latency before the
// first bit); clear holds it for a clearing pass over the whole store, one entry per cycle,
// then the load. After reset busy stays high in S_SWEEP while the store is cleared. The single
// store write port sets this sequencing. Configuration writes are taken at any edge.
`default_nettype none

module led_pwm_channel_store_shift_out #(
  parameter int MAX_DRIVERS = lpwm_pkg::DEF_MAX_DRIVERS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  lpwm_pkg::item_t                 item,
  output logic                            done,
  output lpwm_pkg::res_t                  res,
  input  logic                            cfg_we,
  input  logic [lpwm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lpwm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lpwm_pkg::*;

  localparam int DEPTH  = MAX_DRIVERS * CHANNELS_PER_DRIVER;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LED_W  = INDEX_W + 2;
  localparam int CMP_W  = ((LED_W > ADDR_W) ? LED_W : ADDR_W) + 1;
  localparam int MAXD_W = $clog2(MAX_DRIVERS + 1);
  localparam int DW     = (MAXD_W > DRV_W) ? MAXD_W : DRV_W;

  typedef enum logic [2:0] {S_SWEEP, S_IDLE, S_LED, S_LOAD0, S_LOAD1} state_t;

  state_t                state;
  logic [ADDR_W-1:0]     sweep_cnt;
  logic                  load_after;
  logic [1:0]            led_cnt;
  logic [DRV_W-1:0]      num_drivers;
  logic [LEVEL_BITS-1:0] global_level;

  logic [LED_W-1:0]      led_addr;
  logic [LEVEL_BITS-1:0] led_lvl [3];
  logic [2:0]            led_ok;

  logic                  accept;
  logic                  is_tick;
  logic                  cmd;
  logic                  launch;
  logic                  load;
  logic                  tick;
  logic [DW-1:0]         drv_eff;
  logic [CMP_W-1:0]      limit;
  logic [ADDR_W-1:0]     top_chan;
  logic [LED_W-1:0]      led_base;
  logic [LEVEL_BITS-1:0] single_lvl;
  logic                  single_ok;

  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [LEVEL_BITS-1:0] wdata;
  logic [ADDR_W-1:0]     raddr;
  logic [LEVEL_BITS-1:0] rdata;
  shift_stat_t           stat;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign is_tick = (item.func == FN_TICK);
  assign cmd     = accept && !is_tick && !stat.active;
  assign launch  = cmd && ((item.func == FN_CLEAR) || (item.func == FN_WRITE));
  assign load    = (state == S_LOAD1);
  assign tick    = accept && is_tick;

  always_comb begin
    if (num_drivers == '0) begin
      drv_eff = DW'(1);
    end else if (DW'(num_drivers) > DW'(MAX_DRIVERS)) begin
      drv_eff = DW'(MAX_DRIVERS);
    end else begin
      drv_eff = DW'(num_drivers);
    end
  end

  assign limit    = CMP_W'(drv_eff) * CMP_W'(CHANNELS_PER_DRIVER);
  assign top_chan = ADDR_W'(limit - CMP_W'(1));
  assign led_base = (LED_W'(item.index) << 1) + LED_W'(item.index);

  assign single_lvl = ((item.func == FN_SET_STATE) && (item.value_a == STATE_USE_GLOBAL))
                      ? global_level : clamp_level(item.value_a);
  assign single_ok  = cmd && ((item.func == FN_SET_PWM) || (item.func == FN_SET_STATE))
                      && (CMP_W'(item.index) < limit);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    unique case (state)
      S_SWEEP: begin
        we    = 1'b1;
        waddr = sweep_cnt;
      end
      S_LED: begin
        we    = led_ok[0];
        waddr = ADDR_W'(led_addr);
        wdata = led_lvl[0];
      end
      S_IDLE: begin
        we    = single_ok;
        waddr = ADDR_W'(item.index);
        wdata = single_lvl;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      sweep_cnt    <= '0;
      load_after   <= 1'b0;
      led_cnt      <= '0;
      num_drivers  <= NUM_DRIVERS_RST;
      global_level <= GLOBAL_LEVEL_RST;
      done         <= 1'b0;
      res          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_NUM_DRIVERS:  num_drivers  <= cfg_data[DRV_W-1:0];
          CFG_GLOBAL_LEVEL: global_level <= cfg_data[LEVEL_BITS-1:0];
        endcase
      end

      done            <= accept;
      res.serial_data <= tick && stat.serial_data;
      res.bit_strobe  <= tick && stat.bit_strobe;
      res.latch_pulse <= tick && stat.latch_pulse;
      res.busy_res    <= launch || (stat.active && !(tick && stat.latch_pulse));

      unique case (state)
        S_SWEEP: begin
          if (sweep_cnt == ADDR_W'(DEPTH - 1)) begin
            sweep_cnt  <= '0;
            load_after <= 1'b0;
            state      <= load_after ? S_LOAD0 : S_IDLE;
          end else begin
            sweep_cnt <= sweep_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd) begin
            if (item.func == FN_CLEAR) begin
              load_after <= 1'b1;
              state      <= S_SWEEP;
            end else if (item.func == FN_WRITE) begin
              state <= S_LOAD0;
            end else if (item.func == FN_SET_LED) begin
              led_cnt <= '0;
              state   <= S_LED;
            end
          end
        end
        S_LED: begin
          led_cnt <= led_cnt + 1'b1;
          if (led_cnt == 2'd2) begin
            state <= S_IDLE;
          end
        end
        S_LOAD0: state <= S_LOAD1;
        S_LOAD1: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // hold the three LED levels and advance one per cycle
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      led_addr   <= led_base;
      led_lvl[0] <= clamp_level(item.value_a);
      led_lvl[1] <= clamp_level(item.value_b);
      led_lvl[2] <= clamp_level(item.value_c);
      led_ok[0]  <= CMP_W'(led_base) < limit;
      led_ok[1]  <= (CMP_W'(led_base) + CMP_W'(1)) < limit;
      led_ok[2]  <= (CMP_W'(led_base) + CMP_W'(2)) < limit;
    end else if (state == S_LED) begin
      led_addr   <= led_addr + 1'b1;
      led_lvl[0] <= led_lvl[1];
      led_lvl[1] <= led_lvl[2];
      led_ok     <= {1'b0, led_ok[2:1]};
    end
  end

  lpwm_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  lpwm_shift #(
    .ADDR_W (ADDR_W)
  ) u_shift (
    .clk      (clk),
    .rst      (rst),
    .launch   (launch),
    .top_chan (top_chan),
    .load     (load),
    .tick     (tick),
    .rdata    (rdata),
    .raddr    (raddr),
    .stat     (stat)
  );

  a_word_answered: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted word produced no result");

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    (done && res.bit_strobe) |-> res.busy_res)
    else $error("bit shifted without a transfer in progress");

  a_latch_ends: assert property (@(posedge clk) disable iff (rst)
    (done && res.latch_pulse) |-> (!res.busy_res && !res.bit_strobe))
    else $error("latch pulse did not end the transfer");

  a_no_write_in_xfer: assert property (@(posedge clk) disable iff (rst)
    ((state == S_IDLE) && stat.active) |-> !we)
    else $error("store written during a transfer");

  a_load_active: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD1) |-> stat.active)
    else $error("shift register loaded outside a transfer");

endmodule

`default_nettype wire
